// ===== rtl/bounded_queue_service_monitor_top_assert.svh =====
// Assertion macros for the bounded queue service monitor.
// Needs signals clk and rst in the scope where the macros are used.
`ifndef BOUNDED_QUEUE_SERVICE_MONITOR_TOP_ASSERT_SVH
`define BOUNDED_QUEUE_SERVICE_MONITOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define BQSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BQSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/bqsm_pkg.sv =====
// Shared types and constants for the bounded queue service monitor.
// No dependencies.
package bqsm_pkg;

  // Default structural parameters
  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_TIME_WIDTH  = 32;

  // Configuration register widths, indexes and reset values
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SVC_W      = 16;
  localparam int LIMIT_W    = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SERVICE_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = CFG_IDX_W'(1);

  localparam logic [SVC_W-1:0]   SERVICE_TICKS_RST = SVC_W'(1);
  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RST   = LIMIT_W'(64);

  // Result field widths
  localparam int CNT_W  = 32;
  localparam int SUM_W  = 40;
  localparam int WAIT_W = 32;
  localparam int OCC_W  = 7;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

  // Per-tick event flags passed from the queue to the totals
  typedef struct packed {
    logic served;
    logic dropped;
  } tick_evt_t;

endpackage

// ===== rtl/bqsm_ram.sv =====
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module bqsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written returns old data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/bqsm_queue.sv =====
// Stamp queue, server busy counter and tick clock of the monitor.
// Depends on bqsm_pkg and bqsm_ram.
module bqsm_queue #(
  parameter int QUEUE_DEPTH = bqsm_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = bqsm_pkg::DEF_TIME_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               fire,
  input  logic                               arrived,
  input  logic [bqsm_pkg::SVC_W-1:0]         service_ticks,
  input  logic [bqsm_pkg::LIMIT_W-1:0]       queue_limit,
  output bqsm_pkg::tick_evt_t                evt,
  output logic [TIME_WIDTH-1:0]              wait_val,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count_next
);
  import bqsm_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  // State
  logic [TIME_WIDTH-1:0] tick_now;
  logic [AW-1:0]         head_slot;
  logic [CW-1:0]         entry_count;
  logic [SVC_W-1:0]      busy_left;
  logic                  byp_valid;
  logic [TIME_WIDTH-1:0] byp_data;

  logic [LW-1:0]         limit_eff;
  logic                  can_push;
  logic [CW-1:0]         count_mid;
  logic [AW:0]           tail_sum;
  logic [AW-1:0]         tail_slot;
  logic                  pop;
  logic [TIME_WIDTH-1:0] rd_stamp;
  logic [TIME_WIDTH-1:0] head_stamp;
  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_slot_next;
  logic [SVC_W-1:0]      busy_after;
  logic [SVC_W-1:0]      busy_left_next;
  logic                  wr_en;

  // Effective limit: anything above the depth acts as the depth
  always_comb begin
    if (LW'(queue_limit) > LW'(QUEUE_DEPTH)) begin
      limit_eff = LW'(QUEUE_DEPTH);
    end else begin
      limit_eff = LW'(queue_limit);
    end
  end

  // Arrival: push or drop
  assign can_push  = arrived && (LW'(entry_count) < limit_eff);
  assign count_mid = entry_count + CW'(can_push);

  // Tail slot, head plus count modulo depth
  assign tail_sum = {1'b0, head_slot} + (AW+1)'(entry_count);
  always_comb begin
    if (tail_sum >= (AW+1)'(QUEUE_DEPTH)) begin
      tail_slot = AW'(tail_sum - (AW+1)'(QUEUE_DEPTH));
    end else begin
      tail_slot = tail_sum[AW-1:0];
    end
  end

  // Service: pop the head when idle and something waits
  assign pop = (busy_left == '0) && (count_mid != '0);

  // Head stamp: an empty queue can only serve this tick's own arrival
  always_comb begin
    if (entry_count == '0) begin
      head_stamp = tick_now;
    end else if (byp_valid) begin
      head_stamp = byp_data;
    end else begin
      head_stamp = rd_stamp;
    end
  end

  assign wait_val = pop ? (tick_now - head_stamp) : '0;

  assign head_inc = (head_slot == AW'(QUEUE_DEPTH - 1)) ? '0 : head_slot + AW'(1);
  assign head_slot_next = (fire && pop) ? head_inc : head_slot;
  assign count_next = count_mid - CW'(pop);

  // Busy counter loads on service, then counts down once per tick
  assign busy_after = pop ? service_ticks : busy_left;
  assign busy_left_next = (busy_after != '0) ? busy_after - SVC_W'(1) : '0;

  assign evt.served  = pop;
  assign evt.dropped = arrived && !can_push;

  assign wr_en = fire && can_push;

  // Stamp store; the read address runs one tick ahead so the head is ready
  bqsm_ram #(
    .WIDTH (TIME_WIDTH),
    .DEPTH (QUEUE_DEPTH)
  ) u_stamp_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_slot),
    .wr_data (tick_now),
    .rd_addr (head_slot_next),
    .rd_data (rd_stamp)
  );

  // Queue state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now    <= '0;
      head_slot   <= '0;
      entry_count <= '0;
      busy_left   <= '0;
      byp_valid   <= 1'b0;
    end else begin
      // write to the slot being read lands in RAM too late; forward it
      byp_valid <= wr_en && (tail_slot == head_slot_next);
      if (fire) begin
        tick_now    <= tick_now + TIME_WIDTH'(1);
        head_slot   <= head_slot_next;
        entry_count <= count_next;
        busy_left   <= busy_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= tick_now;
  end

endmodule

// ===== rtl/bqsm_totals.sv =====
// Saturating running totals of served items, waits, drops and occupancy.
// Depends on bqsm_pkg.
module bqsm_totals #(
  parameter int TIME_WIDTH = bqsm_pkg::DEF_TIME_WIDTH,
  parameter int COUNT_W    = 7
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  bqsm_pkg::tick_evt_t        evt,
  input  logic [TIME_WIDTH-1:0]      wait_val,
  input  logic [COUNT_W-1:0]         count_next,
  output logic [bqsm_pkg::CNT_W-1:0] served_sum,
  output logic [bqsm_pkg::SUM_W-1:0] wait_sum,
  output logic [bqsm_pkg::CNT_W-1:0] drop_sum,
  output logic [bqsm_pkg::SUM_W-1:0] occupancy_sum
);
  import bqsm_pkg::*;

  localparam int WSW = ((TIME_WIDTH > SUM_W) ? TIME_WIDTH : SUM_W) + 1;
  localparam int OSW = ((COUNT_W > SUM_W) ? COUNT_W : SUM_W) + 1;

  logic [WSW-1:0]   wait_add;
  logic [OSW-1:0]   occ_add;
  logic [SUM_W-1:0] wait_sum_next;
  logic [SUM_W-1:0] occupancy_sum_next;

  // Wide adds, clamped at the all-ones total
  assign wait_add = WSW'(wait_sum) + WSW'(wait_val);
  assign occ_add  = OSW'(occupancy_sum) + OSW'(count_next);

  assign wait_sum_next = (wait_add >= WSW'(SUM_MAX)) ? SUM_MAX : wait_add[SUM_W-1:0];
  assign occupancy_sum_next = (occ_add >= OSW'(SUM_MAX)) ? SUM_MAX : occ_add[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      served_sum    <= '0;
      wait_sum      <= '0;
      drop_sum      <= '0;
      occupancy_sum <= '0;
    end else if (fire) begin
      if (evt.served && (served_sum != CNT_MAX)) begin
        served_sum <= served_sum + CNT_W'(1);
      end
      if (evt.dropped && (drop_sum != CNT_MAX)) begin
        drop_sum <= drop_sum + CNT_W'(1);
      end
      wait_sum      <= wait_sum_next;
      occupancy_sum <= occupancy_sum_next;
    end
  end

endmodule

// ===== rtl/bounded_queue_service_monitor_top.sv =====
// Top level of the bounded queue service monitor: channels, config registers, result register.
// Depends on bqsm_pkg, bqsm_queue, bqsm_totals and the assertion macro header.
//
// Usage:
//  - Input channel (in_valid / in_stall, payload arrived): one transaction per simulated
//    tick, saying whether an item arrived during that tick.
//  - Output channel (out_valid / out_stall): one result transaction per tick with the
//    per-tick flags, the wait of the served item, end-of-tick occupancy and the
//    saturating totals.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is the
//    service time, index 1 the queue limit; other indexes are ignored. cfg_ready is
//    always high; write only while no tick is in flight.
//  - Path: an accepted tick is held in the input register, then its result is loaded
//    into the result register and presented from there.
//  - Throughput: one tick per cycle while no result is held by out_stall, set by the single
//    pass through the queue logic and the registered-read stamp memory, whose read address runs a tick ahead.
//  - Stall: while out_stall holds a result, one more tick is taken into the input
//    register, then in_stall rises until the result is taken.
//  - Reset: counters, totals and queue state clear; the config registers return to
//    service time 1 and limit 64. No memory clearing pass is needed.
module bounded_queue_service_monitor_top #(
  parameter int QUEUE_DEPTH = bqsm_pkg::DEF_QUEUE_DEPTH,
  parameter int TIME_WIDTH  = bqsm_pkg::DEF_TIME_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst,
  // tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            arrived,
  // results
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            served,
  output logic                            dropped,
  output logic [bqsm_pkg::WAIT_W-1:0]     wait_ticks,
  output logic [bqsm_pkg::OCC_W-1:0]      occupancy,
  output logic [bqsm_pkg::CNT_W-1:0]      served_total,
  output logic [bqsm_pkg::SUM_W-1:0]      wait_total,
  output logic [bqsm_pkg::CNT_W-1:0]      drop_total,
  output logic [bqsm_pkg::SUM_W-1:0]      occupancy_total,
  // configuration
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bqsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bqsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bqsm_pkg::*;

  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int OW  = (CW > OCC_W) ? CW : OCC_W;
  localparam int WW  = (TIME_WIDTH > WAIT_W) ? TIME_WIDTH : WAIT_W;

  logic [SVC_W-1:0]      service_ticks;
  logic [LIMIT_W-1:0]    queue_limit;
  logic                  in_full;
  logic                  in_arrived;
  logic                  fire;
  tick_evt_t             evt;
  logic [TIME_WIDTH-1:0] wait_val;
  logic [CW-1:0]         count_next;
  logic [WW-1:0]         wait_wide;
  logic [OW-1:0]         occ_wide;

  // Config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      service_ticks <= SERVICE_TICKS_RST;
      queue_limit   <= QUEUE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SERVICE_TICKS: service_ticks <= cfg_data[SVC_W-1:0];
        CFG_QUEUE_LIMIT:   queue_limit   <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: process the held tick when the result register is free
  assign fire     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !fire;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_arrived <= arrived;
    end
  end

  bqsm_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_WIDTH  (TIME_WIDTH)
  ) u_queue (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .arrived       (in_arrived),
    .service_ticks (service_ticks),
    .queue_limit   (queue_limit),
    .evt           (evt),
    .wait_val      (wait_val),
    .count_next    (count_next)
  );

  // Totals are loaded with the result, so they form part of the result register
  bqsm_totals #(
    .TIME_WIDTH (TIME_WIDTH),
    .COUNT_W    (CW)
  ) u_totals (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .evt           (evt),
    .wait_val      (wait_val),
    .count_next    (count_next),
    .served_sum    (served_total),
    .wait_sum      (wait_total),
    .drop_sum      (drop_total),
    .occupancy_sum (occupancy_total)
  );

  // Wait report clamps at 32 bits; occupancy is the low bits of the count
  assign wait_wide = WW'(wait_val);
  assign occ_wide  = OW'(count_next);

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      served     <= evt.served;
      dropped    <= evt.dropped;
      wait_ticks <= (wait_wide > WW'(WAIT_MAX)) ? WAIT_MAX : wait_wide[WAIT_W-1:0];
      occupancy  <= occ_wide[OCC_W-1:0];
    end
  end

  // Checks
  `include "bounded_queue_service_monitor_top_assert.svh"

  `BQSM_ASSERT_NOW(a_stall_only_when_full, in_stall, in_full, "input stalled with nothing held")
  `BQSM_ASSERT_NEXT(a_fire_gives_result, fire, out_valid, "processed tick left no result")
  `BQSM_ASSERT_NOW(a_idle_wait_zero, out_valid && !served, wait_ticks == '0, "wait without service")
  `BQSM_ASSERT_NEXT(a_served_counts, fire && evt.served, served_total != '0, "service not counted")

endmodule
